FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL; included by rgb_to_hsv_converter.sv.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge outside reset.
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition never true at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_AT(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

FILE: hw/rtl/rgb2hsv_pkg.sv
// Constants, stage types and the divider step for the RGB to HSV converter.
// No dependencies.
`default_nettype none

package rgb2hsv_pkg;

  localparam int FRAC_BITS = 6;

  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int PCT_W = 13;
  localparam int NUM_W = 11;  // hue numerator, below 6*d

  // Quotient bits produced by the divider: enough for every lane and output.
  localparam int HUE_Q_W = 9 + FRAC_BITS;
  localparam int NSTEP   = (HUE_Q_W > HUE_W) ? HUE_Q_W : HUE_W;
  localparam int DIV_W   = NSTEP + CH_W;

  localparam logic [DIV_W-1:0] HUE_SCALE = DIV_W'(60 << FRAC_BITS);
  localparam logic [DIV_W-1:0] PCT_SCALE = DIV_W'(100 << FRAC_BITS);

  // Brightness divides by a constant: scale*mx/255 = WHOLE*mx + FRAC*mx/255.
  // FRAC*mx stays below 255*258, where z/255 == ((z+1)*257) >> 16.
  localparam int BRI_WHOLE = (100 << FRAC_BITS) / 255;
  localparam int BRI_FRAC  = (100 << FRAC_BITS) % 255;

  // Unshifted quotient bounds.
  localparam logic [NSTEP-1:0] HUE_LIMIT = NSTEP'(360 << FRAC_BITS);
  localparam logic [NSTEP-1:0] PCT_MAX   = NSTEP'(100 << FRAC_BITS);

  // work holds {remainder, dividend bits still to shift in / quotient so far}
  typedef struct packed {
    logic [DIV_W-1:0] work;
    logic [CH_W-1:0]  divisor;
  } lane_t;

  typedef struct packed {
    logic             valid;
    lane_t            hue;
    lane_t            sat;
    logic [PCT_W-1:0] bri;
  } div_stage_t;

  // One restoring division step: one quotient bit.
  function automatic lane_t div_step(lane_t l);
    lane_t          r;
    logic [CH_W:0]  t;
    logic [CH_W:0]  diff;
    logic           ge;
    t    = {l.work[DIV_W-1 -: CH_W], l.work[NSTEP-1]};
    ge   = (t >= {1'b0, l.divisor});
    diff = t - {1'b0, l.divisor};
    r.divisor = l.divisor;
    r.work    = {(ge ? diff[CH_W-1:0] : t[CH_W-1:0]), l.work[NSTEP-2:0], ge};
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter: a pixel passes stage 1, stage 2 (divider load) and the
// divider stages in turn; one pixel per cycle sustained while the sink keeps up.
// Throughput is set by a fully pipelined restoring divider, one quotient bit
// per stage, two lanes (hue, saturation) side by side; brightness comes from
// a constant reciprocal and rides along with them.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_ni, async active low) clears all stage valid bits.
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsv_converter
  import rgb2hsv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CH_W-1:0]   red_i,
  input  wire logic [CH_W-1:0]   green_i,
  input  wire logic [CH_W-1:0]   blue_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [HUE_W-1:0]       hue_o,
  output logic [PCT_W-1:0]       saturation_o,
  output logic [PCT_W-1:0]       brightness_o
);

  // Whole pipeline moves together; it only holds while the last stage
  // has a result the sink has not taken.
  logic advance;
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  // ---------------------------------------------------------------------
  // Stage 1: max, min, spread and the hue numerator k*d + n
  // ---------------------------------------------------------------------
  logic            s1_valid_d, s1_valid_q;
  logic [CH_W-1:0] s1_mx_d, s1_mx_q;
  logic [CH_W-1:0] s1_d_d, s1_d_q;
  logic [NUM_W-1:0] s1_num_d, s1_num_q;

  logic [CH_W-1:0]  mn;
  logic [NUM_W-1:0] r_x, g_x, b_x, d_x;

  always_comb begin
    s1_valid_d = in_valid_i;
    // Ties: red wins over green, green over blue.
    if (red_i >= green_i && red_i >= blue_i) begin
      s1_mx_d = red_i;
    end else if (green_i >= blue_i) begin
      s1_mx_d = green_i;
    end else begin
      s1_mx_d = blue_i;
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    s1_d_d = s1_mx_d - mn;

    r_x = NUM_W'(red_i);
    g_x = NUM_W'(green_i);
    b_x = NUM_W'(blue_i);
    d_x = NUM_W'(s1_d_d);
    // Mod-2^NUM_W arithmetic; the true value is always in 0 .. 6d-1.
    if (red_i >= green_i && red_i >= blue_i) begin
      if (green_i >= blue_i) begin
        s1_num_d = g_x - b_x;
      end else begin
        s1_num_d = NUM_W'(6) * d_x + g_x - b_x;
      end
    end else if (green_i >= blue_i) begin
      s1_num_d = NUM_W'(2) * d_x + b_x - r_x;
    end else begin
      s1_num_d = NUM_W'(4) * d_x + r_x - g_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_mx_q  <= s1_mx_d;
      s1_d_q   <= s1_d_d;
      s1_num_q <= s1_num_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: scale the dividends and load the divider.
  // A zero divisor only comes with a zero dividend; it is replaced by one
  // so the quotient comes out zero (grey or black pixel).
  // Brightness is finished here by the constant reciprocal and then
  // only travels with the divider lanes.
  // ---------------------------------------------------------------------
  div_stage_t dv_d [NSTEP+1];
  div_stage_t dv_q [NSTEP+1];

  logic [31:0] bri_whole, bri_part, bri_sum;

  always_comb begin
    bri_whole = 32'(s1_mx_q) * 32'(BRI_WHOLE);
    bri_part  = ((32'(s1_mx_q) * 32'(BRI_FRAC) + 32'd1) * 32'd257) >> 16;
    bri_sum   = bri_whole + bri_part;

    dv_d[0].valid       = s1_valid_q;
    dv_d[0].hue.work    = DIV_W'(s1_num_q) * HUE_SCALE;
    dv_d[0].hue.divisor = (s1_d_q == '0) ? CH_W'(1) : s1_d_q;
    dv_d[0].sat.work    = DIV_W'(s1_d_q) * PCT_SCALE;
    dv_d[0].sat.divisor = (s1_mx_q == '0) ? CH_W'(1) : s1_mx_q;
    dv_d[0].bri         = bri_sum[PCT_W-1:0];
    for (int i = 1; i <= NSTEP; i++) begin
      dv_d[i].valid = dv_q[i-1].valid;
      dv_d[i].hue   = div_step(dv_q[i-1].hue);
      dv_d[i].sat   = div_step(dv_q[i-1].sat);
      dv_d[i].bri   = dv_q[i-1].bri;
    end
  end

  // ---------------------------------------------------------------------
  // Divider stages: one quotient bit per stage per lane
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NSTEP; i++) begin
        dv_q[i] <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i <= NSTEP; i++) begin
        dv_q[i] <= dv_d[i];
      end
    end
  end

  // Last stage is the output register; low bits of each quotient are the result.
  logic [NSTEP-1:0] hue_quo, sat_quo;
  assign hue_quo = dv_q[NSTEP].hue.work[NSTEP-1:0];
  assign sat_quo = dv_q[NSTEP].sat.work[NSTEP-1:0];

  assign out_valid_o  = dv_q[NSTEP].valid;
  assign hue_o        = hue_quo[HUE_W-1:0];
  assign saturation_o = sat_quo[PCT_W-1:0];
  assign brightness_o = dv_q[NSTEP].bri;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `ASSERT_AT(a_in_reaches_s1, clk_i, rst_ni,
             in_valid_i && in_ready_o |=> s1_valid_q,
             "accepted pixel did not enter stage 1")
  `ASSERT_NEVER(a_hue_range, clk_i, rst_ni,
                out_valid_o && (hue_quo >= HUE_LIMIT),
                "hue quotient at or above 360 degrees")
  `ASSERT_NEVER(a_pct_range, clk_i, rst_ni,
                out_valid_o && ((sat_quo > PCT_MAX) || (NSTEP'(dv_q[NSTEP].bri) > PCT_MAX)),
                "saturation or brightness above 100 percent")
  `ASSERT_NEVER(a_rem_bound, clk_i, rst_ni,
                out_valid_o && (dv_q[NSTEP].hue.work[DIV_W-1 -: CH_W] >=
                                dv_q[NSTEP].hue.divisor),
                "hue divider remainder not below divisor")
  `ASSERT_AT(a_stall_holds, clk_i, rst_ni,
             !advance |=> $stable(dv_q[0].valid) && $stable(s1_valid_q),
             "pipeline moved during output stall")

endmodule

`default_nettype wire

FILE: verif/rgb_to_hsv_converter_tb.sv
// Self-checking testbench for rgb_to_hsv_converter: drives pixels over the
// valid/ready input, predicts hue/saturation/brightness and checks each result.
// Depends on rgb2hsv_pkg (widths, FRAC_BITS, NSTEP) and the converter RTL.
`default_nettype none

module rgb_to_hsv_converter_tb;
  import rgb2hsv_pkg::*;

  // Pipeline depth from input transfer to result.
  localparam int PIPE_LATENCY   = NSTEP + 2;
  // Cycles without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Length of the long output hold used to back the pipeline up.
  localparam int LONG_HOLD      = 300;
  localparam int MAX_GAP        = 10;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] bri;
  } hsv_pixel_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [CH_W-1:0]  red_i;
  logic [CH_W-1:0]  green_i;
  logic [CH_W-1:0]  blue_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [HUE_W-1:0] hue_o;
  logic [PCT_W-1:0] saturation_o;
  logic [PCT_W-1:0] brightness_o;

  rgb_to_hsv_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  // Expected results in transfer order, oldest at the front.
  hsv_pixel_t expected_hsv_q[$];
  int         mismatch_count = 0;

  // Idling controls, switched by the test tasks per phase.
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  // Nonzero asks the result sink to hold ready low for that many cycles.
  int hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Exact integer HSV. Hue sector is picked by the largest channel with ties
  // resolved red over green over blue; grey gives hue 0, black gives sat 0.
  function automatic hsv_pixel_t predict_hsv(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                             logic [CH_W-1:0] b);
    hsv_pixel_t px;
    int ri, gi, bi;
    int hi, lo, span, num;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    span = hi - lo;
    px.hue = '0;
    px.sat = '0;
    if (span != 0) begin
      if (hi == ri) begin
        num = (gi - bi) + ((gi < bi) ? 6 * span : 0);
      end else if (hi == gi) begin
        num = (bi - ri) + 2 * span;
      end else begin
        num = (ri - gi) + 4 * span;
      end
      px.hue = HUE_W'(((60 << FRAC_BITS) * num) / span);
    end
    if (hi != 0) px.sat = PCT_W'(((100 << FRAC_BITS) * span) / hi);
    px.bri = PCT_W'(((100 << FRAC_BITS) * hi) / 255);
    return px;
  endfunction

  // Present one pixel after an optional idle gap; returns once transferred.
  // Valid stays high afterwards so a back-to-back pixel needs no dead cycle.
  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_hsv_q.push_back(predict_hsv(r, g, b));
  endtask

  // Drop valid so a held pixel is not taken twice while the sender waits.
  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (expected_hsv_q.size() != 0) @(posedge clk_i);
  endtask

  // Random pixel biased toward the interesting regions: greys, tied maxima
  // and channel extremes, besides plain uniform values.
  task automatic draw_pixel(output logic [CH_W-1:0] r, output logic [CH_W-1:0] g,
                            output logic [CH_W-1:0] b);
    logic [CH_W-1:0] v, w;
    int kind;
    kind = $urandom_range(0, 7);
    r = CH_W'($urandom);
    g = CH_W'($urandom);
    b = CH_W'($urandom);
    v = CH_W'($urandom_range(1, 255));
    w = CH_W'($urandom_range(0, int'(v)));
    case (kind)
      3: begin
        g = r;
        b = r;
      end
      4: begin
        r = v;
        g = v;
        b = w;
      end
      5: begin
        g = v;
        b = v;
        r = w;
      end
      6: begin
        r = v;
        b = v;
        g = w;
      end
      7: begin
        r = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        g = CH_W'($urandom_range(0, 1) != 0 ? $urandom_range(254, 255) : $urandom_range(0, 1));
        b = CH_W'($urandom_range(0, 1) != 0 ? $urandom_range(254, 255) : $urandom_range(0, 1));
      end
      default: ;
    endcase
  endtask

  task automatic send_random_pixels(int count);
    logic [CH_W-1:0] r, g, b;
    repeat (count) begin
      draw_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Greys, black, white, primaries, every kind of tie for the maximum,
  // hue just below 360 and minimum nonzero spans.
  task automatic test_corner_pixels();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd254);
    send_pixel(8'd254, 8'd254, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd170, 8'd85,  8'd255);
    send_pixel(8'd255, 8'd127, 8'd1);
    send_pixel(8'd2,   8'd1,   8'd0);
  endtask

  // Random pixels under each combination of sender and receiver idling.
  task automatic test_random_mix();
    tx_idle = 1'b1; rx_idle = 1'b1;
    send_random_pixels(90);
    tx_idle = 1'b0; rx_idle = 1'b0;
    send_random_pixels(90);
    tx_idle = 1'b1; rx_idle = 1'b0;
    send_random_pixels(90);
    tx_idle = 1'b0; rx_idle = 1'b1;
    send_random_pixels(90);
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall the
  // input while the sender keeps offering pixels back to back.
  task automatic test_output_backpressure();
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    hold_request = LONG_HOLD;
    send_random_pixels(40);
  endtask

  // Sender stops until the pipeline is empty, then resumes.
  task automatic test_sender_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_random_pixels(20);
    release_input();
    wait_for_drain();
    send_random_pixels(20);
  endtask

  // Result sink: per-result random stall, plus the long hold on request.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) stall_left = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  // Compare every result transfer with the oldest expectation.
  initial begin : result_checker
    hsv_pixel_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_hsv_q.size() == 0) begin
          $error("unexpected result: hue %0d sat %0d bri %0d",
                 hue_o, saturation_o, brightness_o);
          mismatch_count++;
        end else begin
          want = expected_hsv_q.pop_front();
          if (hue_o !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, hue_o);
            mismatch_count++;
          end
          if (saturation_o !== want.sat) begin
            $error("saturation: expected %0d, got %0d", want.sat, saturation_o);
            mismatch_count++;
          end
          if (brightness_o !== want.bri) begin
            $error("brightness: expected %0d, got %0d", want.bri, brightness_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Hang detection: counts cycles with no transfer on either side.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    red_i      = '0;
    green_i    = '0;
    blue_i     = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_corner_pixels();
    test_random_mix();
    test_output_backpressure();
    test_sender_pause();

    release_input();
    wait_for_drain();
    // Let any stray extra result show up before the verdict.
    repeat (4 * PIPE_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rgb2hsv_pkg.sv
hw/rtl/rgb_to_hsv_converter.sv
verif/rgb_to_hsv_converter_tb.sv
